@@ src/crc_pkg.sv @@
// Shared constants, job type and octant tables for the midpoint circle rasterizer.
package crc_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    // Offsets are signed: y can fall to -1 on a zero radius.
    localparam int OFF_BITS    = RADIUS_BITS + 2;
    localparam int DEC_BITS    = RADIUS_BITS + 4;
    localparam int PT_BITS     = 13;
    localparam int WIDE_BITS   = (COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS;
    localparam int CALC_BITS   = ((WIDE_BITS > PT_BITS - 1) ? WIDE_BITS : PT_BITS - 1) + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int POINTS      = 8;
    localparam int PHASE_BITS  = $clog2(POINTS);
    localparam logic [PHASE_BITS-1:0] LAST_PHASE = PHASE_BITS'(POINTS - 1);

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // One step of work handed from the front to the back
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [OFF_BITS-1:0]   x;
        logic signed [OFF_BITS-1:0]   y;
        logic                         done;
    } job_t;

    // Octant order: (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y)
    function automatic logic oct_swap(input logic [PHASE_BITS-1:0] phase);
        logic [POINTS-1:0] tbl;
        tbl = 8'b0110_0110;
        return tbl[phase];
    endfunction

    function automatic logic oct_neg_x(input logic [PHASE_BITS-1:0] phase);
        logic [POINTS-1:0] tbl;
        tbl = 8'b0011_1100;
        return tbl[phase];
    endfunction

    function automatic logic oct_neg_y(input logic [PHASE_BITS-1:0] phase);
        logic [POINTS-1:0] tbl;
        tbl = 8'b1111_0000;
        return tbl[phase];
    endfunction

endpackage

@@ src/midpoint_circle_rasterizer.sv @@
// Top level of the midpoint circle rasterizer.
// A start transaction (cmd 0) latches center and radius and yields the eight
// mirrored points of the first step; each advance transaction (cmd 1) yields
// the eight points of the next step, and circle_done marks all points of the
// final step. An advance with no circle in progress is accepted and yields
// nothing. Points leave one per cycle through a single output register while
// out_ready is high, so the output side sets the sustained rate of input
// transactions. The front end updates the decision term in the cycle a
// transaction is accepted and hands the step to a two-entry job queue, so
// input is taken one per cycle while the queue has room, even while the
// output is stalled.
module midpoint_circle_rasterizer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   cmd,
    input  logic signed [crc_pkg::COORD_BITS-1:0]  center_x,
    input  logic signed [crc_pkg::COORD_BITS-1:0]  center_y,
    input  logic        [crc_pkg::RADIUS_BITS-1:0] radius,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [crc_pkg::PT_BITS-1:0]     point_x,
    output logic signed [crc_pkg::PT_BITS-1:0]     point_y,
    output logic                                   last_of_step,
    output logic                                   circle_done
);

    logic          q_full, push, pop, q_valid;
    crc_pkg::job_t push_job, q_job;

    crc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    crc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    crc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

@@ src/crc_front.sv @@
// Front end: takes commands, runs the midpoint decision update, queues step jobs.
module crc_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   cmd,
    input  logic signed [crc_pkg::COORD_BITS-1:0]  center_x,
    input  logic signed [crc_pkg::COORD_BITS-1:0]  center_y,
    input  logic        [crc_pkg::RADIUS_BITS-1:0] radius,
    input  logic                                   q_full,
    output logic                                   push,
    output crc_pkg::job_t                          push_job
);

    logic signed [crc_pkg::OFF_BITS-1:0]   off_x_reg, off_x_next;
    logic signed [crc_pkg::OFF_BITS-1:0]   off_y_reg, off_y_next;
    logic signed [crc_pkg::DEC_BITS-1:0]   dec_reg, dec_next;
    logic signed [crc_pkg::COORD_BITS-1:0] cx_reg, cy_reg;
    logic                                  active_reg;

    logic                                  start;
    logic                                  accept;
    logic signed [crc_pkg::OFF_BITS-1:0]   base_x, base_y;
    logic signed [crc_pkg::DEC_BITS-1:0]   base_d;
    logic signed [crc_pkg::DEC_BITS-1:0]   ext_x, ext_y;
    logic signed [crc_pkg::COORD_BITS-1:0] job_cx, job_cy;
    logic                                  done;

    assign start    = (cmd == crc_pkg::CMD_START);
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    // An advance with no circle in progress is taken and dropped
    assign push     = accept && (start || active_reg);

    // Starting values come straight from the transaction on a start
    always_comb
    begin
        if (start)
        begin
            base_x = '0;
            base_y = signed'(crc_pkg::OFF_BITS'(radius));
            base_d = crc_pkg::DEC_BITS'(1)
                     - signed'(crc_pkg::DEC_BITS'(radius));
            job_cx = center_x;
            job_cy = center_y;
        end
        else
        begin
            base_x = off_x_reg;
            base_y = off_y_reg;
            base_d = dec_reg;
            job_cx = cx_reg;
            job_cy = cy_reg;
        end
    end

    // Midpoint decision update
    always_comb
    begin
        ext_x = crc_pkg::DEC_BITS'(base_x);
        ext_y = crc_pkg::DEC_BITS'(base_y);
        if (base_d[crc_pkg::DEC_BITS-1])
        begin
            dec_next   = base_d + (ext_x <<< 1) + crc_pkg::DEC_BITS'(3);
            off_y_next = base_y;
        end
        else
        begin
            dec_next   = base_d + ((ext_x - ext_y) <<< 1) + crc_pkg::DEC_BITS'(5);
            off_y_next = base_y - crc_pkg::OFF_BITS'(1);
        end
        off_x_next = base_x + crc_pkg::OFF_BITS'(1);
        done       = off_x_next > off_y_next;
    end

    // Job carries the offsets before the update
    always_comb
    begin
        push_job.cx   = job_cx;
        push_job.cy   = job_cy;
        push_job.x    = base_x;
        push_job.y    = base_y;
        push_job.done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            dec_reg    <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            active_reg <= 1'b0;
        end
        else if (push)
        begin
            off_x_reg  <= off_x_next;
            off_y_reg  <= off_y_next;
            dec_reg    <= dec_next;
            cx_reg     <= job_cx;
            cy_reg     <= job_cy;
            active_reg <= !done;
        end
    end

endmodule

@@ src/crc_queue.sv @@
// Short job queue between the front and back ends.
module crc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  crc_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output crc_pkg::job_t q_job
);

    crc_pkg::job_t                  mem_reg [crc_pkg::QUEUE_DEPTH];
    logic [crc_pkg::QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [crc_pkg::QCNT_BITS-1:0]  count_reg;
    logic                           do_push, do_pop;

    assign full    = (count_reg == crc_pkg::QCNT_BITS'(crc_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;
    assign q_job   = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == crc_pkg::QPTR_BITS'(crc_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + crc_pkg::QPTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == crc_pkg::QPTR_BITS'(crc_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + crc_pkg::QPTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + crc_pkg::QCNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - crc_pkg::QCNT_BITS'(1);
            end
        end
    end

endmodule

@@ src/crc_back.sv @@
// Back end: expands one step job into its eight mirrored points.
module crc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  crc_pkg::job_t                       q_job,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [crc_pkg::PT_BITS-1:0]  point_x,
    output logic signed [crc_pkg::PT_BITS-1:0]  point_y,
    output logic                                last_of_step,
    output logic                                circle_done
);

    crc_pkg::job_t                        job_reg;
    logic                                 job_valid_reg;
    logic [crc_pkg::PHASE_BITS-1:0]       phase_reg;
    logic                                 out_valid_reg;
    logic signed [crc_pkg::PT_BITS-1:0]   px_reg, py_reg;
    logic                                 last_reg, done_reg;

    logic                                 out_free, fire, release_job;
    logic signed [crc_pkg::OFF_BITS-1:0]  dx, dy;
    logic signed [crc_pkg::CALC_BITS-1:0] ox, oy, sum_x, sum_y;

    assign out_free    = !out_valid_reg || out_ready;
    assign fire        = job_valid_reg && out_free;
    assign release_job = fire && (phase_reg == crc_pkg::LAST_PHASE);
    assign pop         = (!job_valid_reg || release_job) && q_valid;

    // Mirror the offsets for the current octant
    always_comb
    begin
        dx    = crc_pkg::oct_swap(phase_reg) ? job_reg.y : job_reg.x;
        dy    = crc_pkg::oct_swap(phase_reg) ? job_reg.x : job_reg.y;
        ox    = crc_pkg::CALC_BITS'(dx);
        oy    = crc_pkg::CALC_BITS'(dy);
        sum_x = crc_pkg::CALC_BITS'(job_reg.cx) + (crc_pkg::oct_neg_x(phase_reg) ? -ox : ox);
        sum_y = crc_pkg::CALC_BITS'(job_reg.cy) + (crc_pkg::oct_neg_y(phase_reg) ? -oy : oy);
    end

    // Job holding and phase counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            if (pop)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (release_job)
            begin
                job_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                phase_reg <= release_job ? '0 : phase_reg + crc_pkg::PHASE_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            px_reg   <= signed'(sum_x[crc_pkg::PT_BITS-1:0]);
            py_reg   <= signed'(sum_y[crc_pkg::PT_BITS-1:0]);
            last_reg <= (phase_reg == crc_pkg::LAST_PHASE);
            done_reg <= job_reg.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule
